// ===== rtl/core/triv_pkg.sv =====
// Trivium keystream block: shared types, constants and round functions.
// No dependencies; imported by the controller, datapath and top level.
package triv_pkg;

  // Full 288-bit cipher state, bit i-1 holds s(i)
  typedef logic [287:0] state_t;

  // Input command codes
  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_PROCESS = 1'b1
  } cmd_code_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_WARM
  } ctrl_state_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 8'd3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned HIGH_W     = 16;

  // Warm-up: fixed number of rounds, done a fixed slice per cycle
  localparam int unsigned WARMUP_ROUNDS = 1152;
  localparam int unsigned WARM_STEP     = 32;
  localparam int unsigned WARM_CYCLES   = WARMUP_ROUNDS / WARM_STEP;
  localparam int unsigned CNT_W         = $clog2(WARM_CYCLES);

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // load key/IV into state
    logic warm;     // advance state by one warm-up slice
    logic process;  // run one word of keystream and queue a result
  } triv_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skid_full;  // both result slots occupied
  } triv_stat_t;

  // Keystream bit of the current state
  function automatic logic ks_bit(input state_t s);
    ks_bit = s[65] ^ s[92] ^ s[161] ^ s[176] ^ s[242] ^ s[287];
  endfunction

  // State after one round
  function automatic state_t round_next(input state_t s);
    logic t1, t2, t3;
    t1 = s[65] ^ s[92] ^ (s[90] & s[91]) ^ s[170];
    t2 = s[161] ^ s[176] ^ (s[174] & s[175]) ^ s[263];
    t3 = s[242] ^ s[287] ^ (s[285] & s[286]) ^ s[68];
    round_next = {s[286:177], t2, s[175:93], t1, s[91:0], t3};
  endfunction

endpackage

// ===== rtl/core/triv_ctrl.sv =====
// Trivium controller: input handshake, restart warm-up sequencing.
// Depends on triv_pkg; drives the command struct of triv_datapath.
module triv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  triv_pkg::triv_stat_t stat,
  output triv_pkg::triv_cmd_t  cmd
);
  import triv_pkg::*;

  ctrl_state_t       state, state_next;
  logic [CNT_W-1:0]  warm_cnt, warm_cnt_next;
  logic              accept;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      warm_cnt <= '0;
    end else begin
      state    <= state_next;
      warm_cnt <= warm_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    warm_cnt_next = warm_cnt;
    cmd           = '0;
    in_stall      = 1'b1;
    accept        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = stat.skid_full;
        accept   = in_valid && !stat.skid_full;
        if (accept) begin
          if (command == CMD_PROCESS) begin
            cmd.process = 1'b1;
          end else begin
            cmd.load      = 1'b1;
            warm_cnt_next = '0;
            state_next    = ST_WARM;
          end
        end
      end
      ST_WARM: begin
        cmd.warm = 1'b1;
        if (warm_cnt == CNT_W'(WARM_CYCLES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          warm_cnt_next = warm_cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/triv_datapath.sv =====
// Trivium datapath: config registers, 288-bit state, unrolled rounds,
// two-slot result buffer. Depends on triv_pkg.
module triv_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  triv_pkg::triv_cmd_t                  cmd,
  output triv_pkg::triv_stat_t                 stat,
  input  logic                                cfg_write,
  input  logic [triv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [triv_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [WORD_BITS-1:0]                data_in,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [WORD_BITS-1:0]                data_out,
  output logic                                keyed
);
  import triv_pkg::*;

  logic [HALF_W-1:0] key_low, iv_low;
  logic [HIGH_W-1:0] key_high, iv_high;

  state_t            st, st_next;
  state_t            st_warm, st_word;
  logic [WORD_BITS-1:0] ks_word;
  logic              keyed_flag;

  // Result slots: main drives the ports, skid catches one more
  logic              main_valid, skid_valid;
  logic [WORD_BITS-1:0] main_data, skid_data;
  logic              main_keyed, skid_keyed;
  logic              main_valid_next, skid_valid_next;
  logic [WORD_BITS-1:0] main_data_next, skid_data_next;
  logic              main_keyed_next, skid_keyed_next;
  logic              take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      iv_low   <= '0;
      iv_high  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data[HIGH_W-1:0];
        CFG_IV_LOW:   iv_low   <= cfg_data;
        CFG_IV_HIGH:  iv_high  <= cfg_data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // Warm-up slice: WARM_STEP rounds, no output
  always_comb begin
    st_warm = st;
    for (int i = 0; i < WARM_STEP; i++) begin
      st_warm = round_next(st_warm);
    end
  end

  // Process word: WORD_BITS rounds, first bit lands in the MSB
  always_comb begin
    st_word = st;
    ks_word = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      ks_word[WORD_BITS-1-i] = ks_bit(st_word);
      st_word = round_next(st_word);
    end
  end

  // Next cipher state
  always_comb begin
    st_next = st;
    if (cmd.load) begin
      st_next          = '0;
      st_next[79:0]    = {key_high, key_low};
      st_next[172:93]  = {iv_high, iv_low};
      st_next[287:285] = 3'b111;
    end else if (cmd.warm) begin
      st_next = st_warm;
    end else if (cmd.process) begin
      st_next = st_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      keyed_flag <= 1'b0;
    end else begin
      st <= st_next;
      if (cmd.load) begin
        keyed_flag <= 1'b1;
      end
    end
  end

  // Result buffer: drain main on transfer, refill from skid, then enqueue
  always_comb begin
    take            = main_valid && !out_stall;
    main_valid_next = main_valid;
    main_data_next  = main_data;
    main_keyed_next = main_keyed;
    skid_valid_next = skid_valid;
    skid_data_next  = skid_data;
    skid_keyed_next = skid_keyed;
    if (take) begin
      main_valid_next = skid_valid;
      main_data_next  = skid_data;
      main_keyed_next = skid_keyed;
      skid_valid_next = 1'b0;
    end
    if (cmd.process) begin
      if (!main_valid_next) begin
        main_valid_next = 1'b1;
        main_data_next  = data_in ^ ks_word;
        main_keyed_next = keyed_flag;
      end else begin
        skid_valid_next = 1'b1;
        skid_data_next  = data_in ^ ks_word;
        skid_keyed_next = keyed_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main_data  <= main_data_next;
    main_keyed <= main_keyed_next;
    skid_data  <= skid_data_next;
    skid_keyed <= skid_keyed_next;
  end

  assign stat.skid_full = skid_valid;
  assign out_valid      = main_valid;
  assign data_out       = main_data;
  assign keyed          = main_keyed;

endmodule

// ===== rtl/core/trivium_keystream_xor.sv =====
// Channel  | Direction | Signals
// ---------+-----------+-------------------------------------------------
// input    | in        | in_valid, in_stall(out), command, data_in
// result   | out       | out_valid, out_stall(in), data_out, keyed
// config   | in        | cfg_valid, cfg_ready(out), cfg_index, cfg_data
//
// A process word runs WORD_BITS Trivium rounds, unrolled into the state
// register's next-value logic; its result is in the output slot the cycle
// after the transfer, or in the skid slot if the output slot is full.
// A restart warm-up runs 32 rounds per cycle; input stalls meanwhile.
// Synchronous active-high reset clears state, config and result slots.
// A two-slot result buffer keeps input flowing while one result is stalled.
module trivium_keystream_xor #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [WORD_BITS-1:0]           data_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [WORD_BITS-1:0]           data_out,
  output logic                           keyed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [triv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [triv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import triv_pkg::*;

  triv_cmd_t  cmd;
  triv_stat_t stat;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  triv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  triv_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_in   (data_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .data_out  (data_out),
    .keyed     (keyed)
  );

endmodule

// ===== test/trivium_keystream_xor_tb.sv =====
// Self-checking testbench for the Trivium keystream XOR block: a scoreboard
// class predicts each pad word while plain tasks drive the three channels.
// Depends on triv_pkg and the trivium_keystream_xor top level only.
module trivium_keystream_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import triv_pkg::*;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned N_ITEMS       = 1350;
  localparam int unsigned SETTLE_CYCLES = 45;    // covers a restart warm-up
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int unsigned MAX_REPORTS   = 10;

  // One predicted result word
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              keyed;
  } pad_word_t;

  // Cipher predictor plus the queue of results still to come
  class keystream_scoreboard;
    logic [287:0]  cipher_st;  // bit i-1 holds s(i)
    logic [63:0]   key_lo, iv_lo;
    logic [15:0]   key_hi, iv_hi;
    logic          keyed;
    pad_word_t     expected_q[$];
    int unsigned   errors, results_seen, restarts, reg_writes;

    function new();
      cipher_st = '0;
      key_lo = '0; key_hi = '0; iv_lo = '0; iv_hi = '0;
      keyed = 1'b0;
      errors = 0; results_seen = 0; restarts = 0; reg_writes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        CFG_KEY_LOW:  key_lo = val;
        CFG_KEY_HIGH: key_hi = val[15:0];
        CFG_IV_LOW:   iv_lo  = val;
        CFG_IV_HIGH:  iv_hi  = val[15:0];
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    // One Trivium round; returns the keystream bit of the old state
    function logic advance_round();
      logic z, fb_a, fb_b, fb_c;
      z    = cipher_st[65] ^ cipher_st[92] ^ cipher_st[161] ^ cipher_st[176]
           ^ cipher_st[242] ^ cipher_st[287];
      fb_b = cipher_st[65] ^ cipher_st[92] ^ (cipher_st[90] & cipher_st[91])
           ^ cipher_st[170];
      fb_c = cipher_st[161] ^ cipher_st[176] ^ (cipher_st[174] & cipher_st[175])
           ^ cipher_st[263];
      fb_a = cipher_st[242] ^ cipher_st[287] ^ (cipher_st[285] & cipher_st[286])
           ^ cipher_st[68];
      cipher_st      = {cipher_st[286:0], 1'b0};
      cipher_st[0]   = fb_a;
      cipher_st[93]  = fb_b;
      cipher_st[177] = fb_c;
      return z;
    endfunction

    function void note_input(cmd_code_t cmd, logic [DATA_W-1:0] din);
      pad_word_t         res;
      logic [DATA_W-1:0] pad;
      if (cmd == CMD_RESTART) begin
        // key into s1..s80, IV into s94..s173, s286..s288 set, then warm-up
        cipher_st          = '0;
        cipher_st[79:0]    = {key_hi, key_lo};
        cipher_st[172:93]  = {iv_hi, iv_lo};
        cipher_st[287:285] = 3'b111;
        repeat (WARMUP_ROUNDS) void'(advance_round());
        keyed = 1'b1;
        restarts++;
      end else begin
        pad = '0;
        repeat (DATA_W) pad = {pad[DATA_W-2:0], advance_round()};
        res.data  = din ^ pad;
        res.keyed = keyed;
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] dout, logic k);
      pad_word_t exp_w;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result data_out=%h keyed=%b", $realtime, dout, k);
        return;
      end
      exp_w = expected_q.pop_front();
      if (dout !== exp_w.data || k !== exp_w.keyed) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %0d mismatch: data_out exp %h got %h, keyed exp %b got %b",
                   $realtime, results_seen, exp_w.data, dout, exp_w.keyed, k);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // Block ports; the inputs are at known values from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  command   = 1'b1;
  logic [DATA_W-1:0]     data_in   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     data_out;
  logic                  keyed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  keystream_scoreboard sb = new();

  bit          steady       = 1'b0;  // no idling on either side this phase
  bit          hold_off_req = 1'b0;  // receiver does one long hold-off
  int unsigned items_sent   = 0;
  int unsigned inputs_seen  = 0;
  int unsigned quiet_cycles = 0;

  trivium_keystream_xor #(.WORD_BITS(DATA_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .keyed     (keyed),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitors: sample pre-edge values of every channel
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(data_out, keyed);
      if (in_valid && !in_stall) begin
        inputs_seen++;
        sb.note_input(cmd_code_t'(command), data_in);
      end
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog: any transfer on any channel resets the quiet count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall before each result unless steady, one long hold-off on request
  initial begin
    int unsigned wait_n;
    wait (!rst);
    forever begin
      wait_n = steady ? 0 : $urandom_range(0, 14);
      if (hold_off_req) begin
        wait_n       = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one item after a random gap, or at once when steady; returns at the edge of its transfer
  task automatic send_item(cmd_code_t cmd, logic [DATA_W-1:0] din);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    data_in  <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every expected result is in and any warm-up has run out
  task automatic settle();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load key and IV registers, with a stray write to an unmapped index first
  task automatic program_cipher(logic [63:0] k_lo, logic [63:0] k_hi,
                                logic [63:0] v_lo, logic [63:0] v_hi);
    cfg_transfer(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
    cfg_transfer(CFG_KEY_LOW,  k_lo);
    cfg_transfer(CFG_KEY_HIGH, k_hi);
    cfg_transfer(CFG_IV_LOW,   v_lo);
    cfg_transfer(CFG_IV_HIGH,  v_hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] draw_cfg_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] draw_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Main sequence
  initial begin
    int unsigned phase, run_len;
    cmd_code_t   cmd;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unkeyed block: pad is zero, keyed stays low
    steady = 1'b1;
    send_item(CMD_PROCESS, '0);
    send_item(CMD_PROCESS, '1);
    send_item(CMD_PROCESS, 32'hA5C3_0F96);
    in_valid <= 1'b0;
    settle();

    // All-zero key and IV
    steady = 1'b0;
    program_cipher('0, '0, '0, '0);
    send_item(CMD_RESTART, '1);
    send_item(CMD_PROCESS, '0);
    send_item(CMD_PROCESS, '1);
    in_valid <= 1'b0;
    settle();

    // All-ones key and IV; high registers get spare bits set to check masking
    program_cipher('1, '1, '1, '1);
    send_item(CMD_RESTART, '0);
    send_item(CMD_PROCESS, '0);
    send_item(CMD_PROCESS, '1);
    send_item(CMD_PROCESS, 32'h8000_0000);
    in_valid <= 1'b0;
    settle();

    // New key without restart: the running stream goes on unchanged
    program_cipher({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_item(CMD_PROCESS, 32'h0000_0001);
    send_item(CMD_PROCESS, $urandom);
    // then two restarts back to back pick it up
    steady = 1'b1;
    send_item(CMD_RESTART, $urandom);
    send_item(CMD_RESTART, $urandom);
    send_item(CMD_PROCESS, $urandom);
    send_item(CMD_PROCESS, $urandom);
    in_valid <= 1'b0;

    // Random phases: mostly restart followed by a run of words
    phase = 0;
    while (items_sent < N_ITEMS) begin
      settle();
      phase++;
      steady  = ($urandom_range(0, 5) == 0);
      run_len = $urandom_range(4, 60);
      if (phase == 3) begin
        steady       = 1'b1;
        hold_off_req = 1'b1;
        run_len      = 40;
      end
      if ($urandom_range(0, 3) != 0)
        program_cipher(draw_cfg_word(), draw_cfg_word(), draw_cfg_word(), draw_cfg_word());
      if ($urandom_range(0, 7) != 0)
        send_item(CMD_RESTART, $urandom);
      repeat (run_len) begin
        cmd = ($urandom_range(0, 39) == 0) ? CMD_RESTART : CMD_PROCESS;
        send_item(cmd, draw_data());
      end
      in_valid <= 1'b0;
    end

    settle();
    $display("Covered %0d input transfers (%0d restarts), %0d results, %0d register writes.",
             inputs_seen, sb.restarts, sb.results_seen, sb.reg_writes);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/triv_pkg.sv
rtl/core/triv_ctrl.sv
rtl/core/triv_datapath.sv
rtl/core/trivium_keystream_xor.sv
test/trivium_keystream_xor_tb.sv
